>>> hw/rtl/nmd_pkg.sv
// Shared types, parse phases and dispatch functions of the 9P message decoder.
package nmd_pkg;

    localparam int POSITION_BITS = 32;

    typedef logic [POSITION_BITS-1:0] pos_t;

    typedef enum logic [4:0] {
        PH_SIZE     = 5'd0,
        PH_TYPE     = 5'd1,
        PH_TAG      = 5'd2,
        PH_FID      = 5'd3,
        PH_NEWFID   = 5'd4,
        PH_AFID     = 5'd5,
        PH_MSIZE    = 5'd6,
        PH_STRLEN   = 5'd7,
        PH_STRSKIP  = 5'd8,
        PH_QTYPE    = 5'd9,
        PH_QVERS    = 5'd10,
        PH_QPATH    = 5'd11,
        PH_OLDTAG   = 5'd12,
        PH_NWNAME   = 5'd13,
        PH_NWQID    = 5'd14,
        PH_OMODE    = 5'd15,
        PH_IOUNIT   = 5'd16,
        PH_PERM     = 5'd17,
        PH_OFFSET   = 5'd18,
        PH_COUNT    = 5'd19,
        PH_DATASKIP = 5'd20,
        PH_STATN    = 5'd21,
        PH_STATSIZE = 5'd22,
        PH_STYPE    = 5'd23,
        PH_SDEV     = 5'd24,
        PH_SMODE    = 5'd25,
        PH_ATIME    = 5'd26,
        PH_MTIME    = 5'd27,
        PH_SLEN     = 5'd28,
        PH_DONE     = 5'd29,
        PH_ERR      = 5'd30
    } phase_t;

    // field ids
    localparam logic [4:0] FID_TYPE = 5'd0,  FID_TAG = 5'd1,  FID_FID = 5'd2,
                           FID_AFID = 5'd3,  FID_MSIZE = 5'd4, FID_STR = 5'd5,
                           FID_QTYPE = 5'd6, FID_QVERS = 5'd7, FID_QPATH = 5'd8,
                           FID_OLDTAG = 5'd9, FID_NWNAME = 5'd10, FID_NWQID = 5'd11,
                           FID_MODE = 5'd12, FID_IOUNIT = 5'd13, FID_PERM = 5'd14,
                           FID_OFFSET = 5'd15, FID_COUNT = 5'd16, FID_DATA = 5'd17,
                           FID_STATN = 5'd18, FID_STATSZ = 5'd19, FID_STYPE = 5'd20,
                           FID_SDEV = 5'd21, FID_STIME = 5'd22, FID_SLEN = 5'd23;

    localparam logic [1:0] ST_OK = 2'd0, ST_TRUNC = 2'd1, ST_MISMATCH = 2'd2,
                           ST_UNSUPP = 2'd3;

    localparam logic [7:0] T_VERSION = 8'd100, R_VERSION = 8'd101, T_AUTH = 8'd102,
                           R_AUTH = 8'd103, T_ATTACH = 8'd104, R_ATTACH = 8'd105,
                           T_ERROR = 8'd106, R_ERROR = 8'd107, T_FLUSH = 8'd108,
                           R_FLUSH = 8'd109, T_WALK = 8'd110, R_WALK = 8'd111,
                           T_OPEN = 8'd112, R_OPEN = 8'd113, T_CREATE = 8'd114,
                           R_CREATE = 8'd115, T_READ = 8'd116, R_READ = 8'd117,
                           T_WRITE = 8'd118, R_WRITE = 8'd119, T_CLUNK = 8'd120,
                           R_CLUNK = 8'd121, T_REMOVE = 8'd122, R_REMOVE = 8'd123,
                           T_STAT = 8'd124, R_STAT = 8'd125, T_WSTAT = 8'd126,
                           R_WSTAT = 8'd127;

    typedef struct packed {
        logic        kind;
        logic [4:0]  field_id;
        logic [15:0] element_index;
        logic [63:0] field_value;
        logic [31:0] string_offset;
        logic [1:0]  status;
        logic        last_result;
    } item_t;

    // up to two items produced by one input byte, first slot filled first
    typedef struct packed {
        logic  v0;
        item_t i0;
        logic  v1;
        item_t i1;
    } wr_pair_t;

    function automatic logic [3:0] phase_width(phase_t ph);
        case (ph)
            PH_SIZE, PH_FID, PH_NEWFID, PH_AFID, PH_MSIZE, PH_QVERS, PH_IOUNIT,
            PH_PERM, PH_COUNT, PH_SDEV, PH_SMODE, PH_ATIME, PH_MTIME: return 4'd4;
            PH_TYPE, PH_QTYPE, PH_OMODE: return 4'd1;
            PH_TAG, PH_STRLEN, PH_OLDTAG, PH_NWNAME, PH_NWQID, PH_STATN,
            PH_STATSIZE, PH_STYPE: return 4'd2;
            PH_QPATH, PH_OFFSET, PH_SLEN: return 4'd8;
            default: return 4'd0;
        endcase
    endfunction

    function automatic phase_t start_phase(logic [7:0] t);
        case (t)
            T_VERSION, R_VERSION: return PH_MSIZE;
            T_AUTH: return PH_AFID;
            R_AUTH, R_ATTACH, R_OPEN, R_CREATE: return PH_QTYPE;
            T_ATTACH, T_WALK, T_OPEN, T_CREATE, T_READ, T_WRITE, T_CLUNK,
            T_REMOVE, T_STAT, T_WSTAT: return PH_FID;
            R_ERROR: return PH_STRLEN;
            T_FLUSH: return PH_OLDTAG;
            R_FLUSH, R_CLUNK, R_REMOVE, R_WSTAT: return PH_DONE;
            R_WALK: return PH_NWQID;
            R_READ, R_WRITE: return PH_COUNT;
            R_STAT: return PH_STATN;
            default: return PH_ERR;
        endcase
    endfunction

    function automatic phase_t after_fid(logic [7:0] t);
        case (t)
            T_ATTACH: return PH_AFID;
            T_WALK: return PH_NEWFID;
            T_OPEN: return PH_OMODE;
            T_CREATE: return PH_STRLEN;
            T_READ, T_WRITE: return PH_OFFSET;
            T_WSTAT: return PH_STATN;
            default: return PH_DONE;
        endcase
    endfunction

    function automatic phase_t after_string(logic [7:0] t, logic [15:0] ecnt,
                                            logic [15:0] erem);
        case (t)
            T_AUTH, T_ATTACH: return (ecnt < 16'd2) ? PH_STRLEN : PH_DONE;
            T_CREATE: return PH_PERM;
            T_WALK: return (erem != 16'd0) ? PH_STRLEN : PH_DONE;
            R_STAT, T_WSTAT: return (ecnt < 16'd4) ? PH_STRLEN : PH_DONE;
            default: return PH_DONE;
        endcase
    endfunction

    function automatic phase_t after_qid(logic [7:0] t);
        case (t)
            R_OPEN, R_CREATE: return PH_IOUNIT;
            R_STAT, T_WSTAT: return PH_SMODE;
            default: return PH_DONE;
        endcase
    endfunction

    function automatic pos_t sat_add(pos_t a, logic [15:0] b);
        logic [POSITION_BITS:0] s;
        s = {1'b0, a} + (POSITION_BITS+1)'(b);
        return s[POSITION_BITS] ? '1 : s[POSITION_BITS-1:0];
    endfunction

endpackage

>>> hw/rtl/nmd_parse.sv
// Per-byte parse state and field decode of the 9P message decoder.
module nmd_parse import nmd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_take,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output wr_pair_t   wr
);

    pos_t        pos_reg, pos_next;
    logic [7:0]  mtype_reg, mtype_next;
    phase_t      ph_reg, ph_next;
    logic [63:0] acc_reg, acc_next;
    logic [3:0]  bcnt_reg, bcnt_next;
    logic [31:0] skip_reg, skip_next;
    logic [15:0] erem_reg, erem_next;
    logic [15:0] ecnt_reg, ecnt_next;
    pos_t        dend_reg, dend_next;
    logic [1:0]  err_reg, err_next;

    pos_t        pos_inc, pos_start;
    logic [63:0] v;
    logic [3:0]  w;
    logic [15:0] ecnt_up, erem_up;
    logic [31:0] skip_dec;
    logic [POSITION_BITS+1:0] stat_end;
    logic        f_valid;
    item_t       f_item, s_item;

    always_comb begin
        pos_next   = pos_reg;
        mtype_next = mtype_reg;
        ph_next    = ph_reg;
        acc_next   = acc_reg;
        bcnt_next  = bcnt_reg;
        skip_next  = skip_reg;
        erem_next  = erem_reg;
        ecnt_next  = ecnt_reg;
        dend_next  = dend_reg;
        err_next   = err_reg;
        f_valid    = 1'b0;
        f_item     = '0;
        s_item     = '0;

        pos_inc   = sat_add(pos_reg, 16'd1);
        pos_start = (pos_reg == '0) ? '0 : pos_reg - pos_t'(1);
        v         = acc_reg | (64'(in_byte) << {bcnt_reg[2:0], 3'b000});
        w         = phase_width(ph_reg);
        ecnt_up   = ecnt_reg + 16'd1;
        erem_up   = (erem_reg != 16'd0) ? erem_reg - 16'd1 : erem_reg;
        skip_dec  = (skip_reg != 32'd0) ? skip_reg - 32'd1 : skip_reg;
        stat_end  = (POSITION_BITS+2)'(pos_start) + (POSITION_BITS+2)'(2)
                    + (POSITION_BITS+2)'(v[15:0]);

        if (ph_reg == PH_ERR) begin
            // ignore everything until the end of the message
        end else if (ph_reg == PH_DONE) begin
            err_next = ST_MISMATCH;
            ph_next  = PH_ERR;
        end else if (ph_reg == PH_STRSKIP || ph_reg == PH_DATASKIP) begin
            skip_next = skip_dec;
            if (skip_dec == 32'd0) begin
                ph_next = (ph_reg == PH_STRSKIP) ?
                          after_string(mtype_reg, ecnt_reg, erem_reg) : PH_DONE;
            end
        end else if (w == 4'd0) begin
            ph_next = PH_ERR;
        end else if ({1'b0, bcnt_reg} + 5'd1 < {1'b0, w}) begin
            acc_next  = v;
            bcnt_next = bcnt_reg + 4'd1;
        end else begin
            acc_next    = '0;
            bcnt_next   = '0;
            f_valid     = 1'b1;
            f_item.field_value = v;
            case (ph_reg)
                PH_SIZE: begin
                    f_valid = 1'b0;
                    ph_next = PH_TYPE;
                end
                PH_TYPE: begin
                    mtype_next      = v[7:0];
                    f_item.field_id = FID_TYPE;
                    if (start_phase(v[7:0]) == PH_ERR) err_next = ST_UNSUPP;
                    ph_next = PH_TAG;
                end
                PH_TAG: begin
                    f_item.field_id = FID_TAG;
                    ecnt_next = '0;
                    erem_next = '0;
                    ph_next   = (err_reg != ST_OK) ? PH_ERR : start_phase(mtype_reg);
                end
                PH_FID: begin
                    f_item.field_id = FID_FID;
                    ph_next = after_fid(mtype_reg);
                end
                PH_NEWFID: begin
                    f_item.field_id      = FID_FID;
                    f_item.element_index = 16'd1;
                    ph_next = PH_NWNAME;
                end
                PH_AFID: begin
                    f_item.field_id = FID_AFID;
                    ph_next = PH_STRLEN;
                end
                PH_MSIZE: begin
                    f_item.field_id = FID_MSIZE;
                    ph_next = PH_STRLEN;
                end
                PH_STRLEN: begin
                    f_item.field_id      = FID_STR;
                    f_item.element_index = ecnt_reg;
                    f_item.string_offset = 32'(pos_inc);
                    ecnt_next = ecnt_up;
                    if (mtype_reg == T_WALK) erem_next = erem_up;
                    if (v[15:0] == 16'd0) begin
                        ph_next = after_string(mtype_reg, ecnt_up,
                                               (mtype_reg == T_WALK) ? erem_up : erem_reg);
                    end else begin
                        skip_next = 32'(v[15:0]);
                        ph_next   = PH_STRSKIP;
                    end
                end
                PH_QTYPE: begin
                    f_item.field_id      = FID_QTYPE;
                    f_item.element_index = ecnt_reg;
                    ph_next = PH_QVERS;
                end
                PH_QVERS: begin
                    f_item.field_id      = FID_QVERS;
                    f_item.element_index = ecnt_reg;
                    ph_next = PH_QPATH;
                end
                PH_QPATH: begin
                    f_item.field_id      = FID_QPATH;
                    f_item.element_index = ecnt_reg;
                    if (mtype_reg == R_WALK) begin
                        ecnt_next = ecnt_up;
                        erem_next = erem_up;
                        ph_next   = (erem_up != 16'd0) ? PH_QTYPE : PH_DONE;
                    end else begin
                        ph_next = after_qid(mtype_reg);
                    end
                end
                PH_OLDTAG: begin
                    f_item.field_id = FID_OLDTAG;
                    ph_next = PH_DONE;
                end
                PH_NWNAME, PH_NWQID: begin
                    f_item.field_id = (ph_reg == PH_NWNAME) ? FID_NWNAME : FID_NWQID;
                    erem_next = v[15:0];
                    ecnt_next = '0;
                    if (v[15:0] == 16'd0) ph_next = PH_DONE;
                    else ph_next = (ph_reg == PH_NWNAME) ? PH_STRLEN : PH_QTYPE;
                end
                PH_OMODE, PH_SMODE: begin
                    f_item.field_id = FID_MODE;
                    ph_next = (ph_reg == PH_OMODE) ? PH_DONE : PH_ATIME;
                end
                PH_IOUNIT: begin
                    f_item.field_id = FID_IOUNIT;
                    ph_next = PH_DONE;
                end
                PH_PERM: begin
                    f_item.field_id = FID_PERM;
                    ph_next = PH_OMODE;
                end
                PH_OFFSET: begin
                    f_item.field_id = FID_OFFSET;
                    ph_next = PH_COUNT;
                end
                PH_COUNT: begin
                    if (mtype_reg == R_READ || mtype_reg == T_WRITE) begin
                        f_item.field_id      = FID_DATA;
                        f_item.string_offset = 32'(pos_inc);
                        if (v[31:0] == 32'd0) begin
                            ph_next = PH_DONE;
                        end else begin
                            skip_next = v[31:0];
                            ph_next   = PH_DATASKIP;
                        end
                    end else begin
                        f_item.field_id = FID_COUNT;
                        ph_next = PH_DONE;
                    end
                end
                PH_STATN: begin
                    f_item.field_id = FID_STATN;
                    dend_next = sat_add(pos_inc, v[15:0]);
                    ecnt_next = '0;
                    ph_next   = PH_STATSIZE;
                end
                PH_STATSIZE: begin
                    f_item.field_id = FID_STATSZ;
                    if (stat_end > (POSITION_BITS+2)'(dend_reg)) begin
                        err_next = ST_MISMATCH;
                        ph_next  = PH_ERR;
                    end else begin
                        ph_next = PH_STYPE;
                    end
                end
                PH_STYPE: begin
                    f_item.field_id = FID_STYPE;
                    ph_next = PH_SDEV;
                end
                PH_SDEV: begin
                    f_item.field_id = FID_SDEV;
                    ph_next = PH_QTYPE;
                end
                PH_ATIME: begin
                    f_item.field_id = FID_STIME;
                    ph_next = PH_MTIME;
                end
                PH_MTIME: begin
                    f_item.field_id      = FID_STIME;
                    f_item.element_index = 16'd1;
                    ph_next = PH_SLEN;
                end
                PH_SLEN: begin
                    f_item.field_id = FID_SLEN;
                    ph_next = PH_STRLEN;
                end
                default: begin
                    f_valid = 1'b0;
                    ph_next = PH_ERR;
                end
            endcase
        end

        // end of message: report status and return to the header start
        s_item.kind        = 1'b1;
        s_item.last_result = 1'b1;
        if (err_next != ST_OK) s_item.status = err_next;
        else if (dend_next != '0 && pos_inc != dend_next) s_item.status = ST_MISMATCH;
        else if (ph_next != PH_DONE) s_item.status = ST_TRUNC;
        else s_item.status = ST_OK;

        if (in_last) begin
            pos_next   = '0;
            mtype_next = '0;
            ph_next    = PH_SIZE;
            acc_next   = '0;
            bcnt_next  = '0;
            skip_next  = '0;
            erem_next  = '0;
            ecnt_next  = '0;
            dend_next  = '0;
            err_next   = ST_OK;
        end else begin
            pos_next = pos_inc;
        end

        wr.v0 = in_take && (f_valid || in_last);
        wr.i0 = f_valid ? f_item : s_item;
        wr.v1 = in_take && f_valid && in_last;
        wr.i1 = s_item;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            mtype_reg <= '0;
            ph_reg    <= PH_SIZE;
            acc_reg   <= '0;
            bcnt_reg  <= '0;
            skip_reg  <= '0;
            erem_reg  <= '0;
            ecnt_reg  <= '0;
            dend_reg  <= '0;
            err_reg   <= ST_OK;
        end else if (in_take) begin
            pos_reg   <= pos_next;
            mtype_reg <= mtype_next;
            ph_reg    <= ph_next;
            acc_reg   <= acc_next;
            bcnt_reg  <= bcnt_next;
            skip_reg  <= skip_next;
            erem_reg  <= erem_next;
            ecnt_reg  <= ecnt_next;
            dend_reg  <= dend_next;
            err_reg   <= err_next;
        end
    end

endmodule

>>> hw/rtl/nmd_out_queue.sv
// Four-entry result queue that takes up to two items per cycle.
module nmd_out_queue import nmd_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  wr_pair_t wr,
    output logic     has_room,
    output logic     out_valid,
    input  logic     out_ready,
    output item_t    out_item
);

    item_t      mem [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       pop;

    assign has_room  = (cnt_reg <= 3'd2);
    assign out_valid = (cnt_reg != 3'd0);
    assign out_item  = mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + 2'(wr.v0) + 2'(wr.v1);
        rd_ptr_next = rd_ptr_reg + 2'(pop);
        cnt_next    = cnt_reg + 3'(wr.v0) + 3'(wr.v1) - 3'(pop);
    end

    always_ff @(posedge aclk) begin
        if (wr.v0) mem[wr_ptr_reg] <= wr.i0;
        if (wr.v1) mem[wr_ptr_reg + 2'd1] <= wr.i1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

>>> hw/rtl/ninep_message_decoder_core.sv
// Top level of the 9P2000 message decoder: byte stream in, field items out.
//
// Input stream: one message byte per item on s_tdata[7:0]; s_tlast marks the
// final byte, and the message size is the number of bytes seen up to it.
// Output stream: one decoded field or one end-of-message status per item.
// m_tuser is 0 for a field and 1 for the status; m_tlast is set only on the
// status item that closes a message.
// Throughput: one input byte per cycle while s_tready is high. A byte that
// completes a field other than the size emits one item, the flagged byte
// emits its status (two items if it also ends a field); all other bytes
// emit nothing. An item is written into the result queue when the byte that
// caused it is accepted; decode is a single combinational pass from the parse
// state registers into that four-entry queue.
// Stall: s_tready drops while the queue holds more than two items, so a
// stalled receiver backs up into the sender without losing items.
// Reset: aresetn (synchronous, active low) empties the queue and returns the
// parser to the start of a message header.
module ninep_message_decoder_core import nmd_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tlast,   // last_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [119:0] m_tdata,   // [4:0] field_id, [20:5] element_index,
                                    // [84:21] field_value, [116:85] string_offset,
                                    // [118:117] status, [119] zero
    output logic         m_tuser,   // item_kind
    output logic         m_tlast    // last_result
);

    wr_pair_t wr;
    item_t    out_item;
    logic     has_room;

    assign s_tready = has_room;

    nmd_parse u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_take (s_tvalid && has_room),
        .in_byte (s_tdata),
        .in_last (s_tlast),
        .wr      (wr)
    );

    nmd_out_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr        (wr),
        .has_room  (has_room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item)
    );

    assign m_tdata = {1'b0, out_item.status, out_item.string_offset,
                      out_item.field_value, out_item.element_index, out_item.field_id};
    assign m_tuser = out_item.kind;
    assign m_tlast = out_item.last_result;

endmodule

>>> hw/rtl/nmd_checker.sv
// Port-level checks of the 9P message decoder, bound to the top level.
module nmd_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [119:0] m_tdata,
    input logic         m_tuser,
    input logic         m_tlast
);

    a_kind_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == m_tlast))
        else $error("status item and last flag disagree");

    a_status_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[116:0] == '0))
        else $error("status item carries field data");

    a_field_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[118:117] == 2'd0))
        else $error("field item carries a status");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result item changed");

endmodule

bind ninep_message_decoder_core nmd_checker u_nmd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
